// File: design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// process table countdown package
// shared constants, opcodes, status codes and entry type
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int TABLE_SLOTS_DEF    = 32;
	localparam int MAX_NAME_CHARS_DEF = 10;
	localparam logic [7:0] CH_FORBIDDEN = 8'h30;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_SUSPEND = 3'd1,
		OP_RESUME  = 3'd2,
		OP_KILL    = 3'd3,
		OP_TICK    = 3'd4,
		OP_LIST    = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_FULL      = 4'd1,
		ST_TOO_LONG  = 4'd2,
		ST_FORBIDDEN = 4'd3,
		ST_TAKEN     = 4'd4,
		ST_MISSING   = 4'd5,
		ST_PAUSED    = 4'd6,
		ST_RUNNING   = 4'd7,
		ST_EMPTY     = 4'd8
	} status_t;

	typedef struct packed {
		logic [63:0] name_low;
		logic [15:0] name_high;
		logic [3:0]  name_len;
		logic [15:0] id;
		logic [31:0] count;
		logic        running;
	} entry_t;

endpackage

// File: design/process_table_countdown.sv
// ----------------------------------------------------------------------------
// process table countdown
// compacted process table with create, suspend, resume, kill, tick and list
// ----------------------------------------------------------------------------
// channel   signals                                         direction
// command   start, busy, operation, name_*, start_count,   in
//           target_id
// result    strobe, status, proc_id, out_name_*, remaining, out
//           is_running, terminated, last
//
// table entries live in a memory with one read and one write port; each entry visited
// passes through check, read and evaluate, and the next entry is not checked until the
// last one is evaluated; busy stays high until the result transfer is done.
// each removal moves each later entry up with a read and a write, so a tick removing
// many entries grows with the square of the fill; errors found at accept need no
// table pass. reset clears the fill count and next id; no clearing pass.
// the receiver cannot stall: results appear with strobe for one cycle each.
module process_table_countdown #(
	parameter int TABLE_SLOTS    = ptc_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_NAME_CHARS = ptc_pkg::MAX_NAME_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [63:0] name_low,
	input  logic [15:0] name_high,
	input  logic [3:0]  name_length,
	input  logic [31:0] start_count,
	input  logic [15:0] target_id,
	output logic        strobe,
	output logic [3:0]  status,
	output logic [15:0] proc_id,
	output logic [63:0] out_name_low,
	output logic [15:0] out_name_high,
	output logic [31:0] remaining,
	output logic        is_running,
	output logic        terminated,
	output logic        last
);
	import ptc_pkg::*;

	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_CHECK = 8'b00000010,
		S_RD    = 8'b00000100,
		S_EVAL  = 8'b00001000,
		S_SHRD  = 8'b00010000,
		S_SHWR  = 8'b00100000,
		S_WRNEW = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	state_t state_q;
	entry_t mem [TABLE_SLOTS];
	entry_t rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	entry_t wr_data;

	logic [CW-1:0] used_q, idx_q, sh_q;
	logic [15:0] next_id_q;
	logic [2:0] op_q;
	logic [63:0] nlo_q;
	logic [15:0] nhi_q;
	logic [3:0] nlen_q;
	logic [31:0] cnt_q;
	logic [15:0] tid_q;
	logic any_q;
	logic after_kill_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// masked name and forbidden check
	logic [63:0] mlo;
	logic [15:0] mhi;
	logic forb;
	always_comb begin
		mlo = 64'd0;
		mhi = 16'd0;
		forb = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i < int'(name_length)) begin
				mlo[8*i +: 8] = name_low[8*i +: 8];
				if (name_low[8*i +: 8] == CH_FORBIDDEN) forb = 1'b1;
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (i + 8 < int'(name_length)) begin
				mhi[8*i +: 8] = name_high[8*i +: 8];
				if (name_high[8*i +: 8] == CH_FORBIDDEN) forb = 1'b1;
			end
		end
	end

	entry_t ent;
	logic [31:0] dec;
	assign ent = rd_q;
	assign dec = ent.count - 32'd1;

	logic out_v;
	status_t out_st;
	entry_t out_e;
	logic out_has, out_term, out_last;

	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = ent;
		unique case (state_q)
			S_SHRD: rd_addr = AW'(sh_q + CW'(1));
			S_SHWR: begin
				wr_en = 1'b1;
				wr_addr = sh_q[AW-1:0];
			end
			S_WRNEW: begin
				wr_en = 1'b1;
				wr_addr = used_q[AW-1:0];
				wr_data.name_low = nlo_q;
				wr_data.name_high = nhi_q;
				wr_data.name_len = nlen_q;
				wr_data.id = next_id_q;
				wr_data.count = cnt_q;
				wr_data.running = 1'b0;
			end
			S_EVAL: begin
				if (op_q == OP_SUSPEND && ent.id == tid_q && ent.running) begin
					wr_en = 1'b1;
					wr_data.running = 1'b0;
				end else if (op_q == OP_RESUME && ent.id == tid_q && !ent.running) begin
					wr_en = 1'b1;
					wr_data.running = 1'b1;
				end else if (op_q == OP_TICK && ent.running && dec != 32'd0) begin
					wr_en = 1'b1;
					wr_data.count = dec;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			next_id_q <= '0;
			out_v <= 1'b0;
			idx_q <= '0;
			sh_q <= '0;
			any_q <= 1'b0;
			after_kill_q <= 1'b0;
		end else begin
			out_v <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						op_q <= operation;
						nlo_q <= mlo;
						nhi_q <= mhi;
						nlen_q <= name_length;
						cnt_q <= start_count;
						tid_q <= target_id;
						idx_q <= '0;
						any_q <= 1'b0;
						out_e <= '0;
						out_term <= 1'b0;
						out_last <= 1'b1;
						if (operation == OP_CREATE) begin
							if (used_q >= CW'(TABLE_SLOTS)) begin
								out_v <= 1'b1; out_st <= ST_FULL; state_q <= S_DONE;
							end else if (name_length > 4'(MAX_NAME_CHARS)) begin
								out_v <= 1'b1; out_st <= ST_TOO_LONG; state_q <= S_DONE;
							end else if (forb) begin
								out_v <= 1'b1; out_st <= ST_FORBIDDEN; state_q <= S_DONE;
							end else
								state_q <= S_CHECK;
						end else if (operation <= OP_LIST)
							state_q <= S_CHECK;
						else
							state_q <= S_DONE;
					end
				end
				S_CHECK: begin
					if (idx_q >= used_q) begin
						if (op_q == OP_CREATE) state_q <= S_WRNEW;
						else begin
							out_v <= 1'b1;
							out_e <= '0;
							out_term <= 1'b0;
							out_last <= 1'b1;
							out_st <= (op_q == OP_TICK || op_q == OP_LIST) ?
								(any_q ? ST_OK : ST_EMPTY) : ST_MISSING;
							if (any_q) begin
								out_v <= 1'b0;
							end
							state_q <= S_DONE;
						end
					end else
						state_q <= S_RD;
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					out_st <= ST_OK;
					out_e <= ent;
					out_term <= 1'b0;
					out_last <= 1'b1;
					state_q <= S_DONE;
					unique case (op_q)
						OP_CREATE: begin
							if (ent.name_len == nlen_q && ent.name_low == nlo_q &&
								ent.name_high == nhi_q) begin
								out_v <= 1'b1; out_st <= ST_TAKEN; out_e <= '0;
							end else begin
								idx_q <= idx_q + CW'(1); state_q <= S_CHECK;
							end
						end
						OP_SUSPEND, OP_RESUME: begin
							if (ent.id == tid_q) begin
								out_v <= 1'b1;
								if (op_q == OP_SUSPEND) begin
									out_e.running <= 1'b0;
									if (!ent.running) out_st <= ST_PAUSED;
								end else begin
									out_e.running <= 1'b1;
									if (ent.running) out_st <= ST_RUNNING;
								end
							end else begin
								idx_q <= idx_q + CW'(1); state_q <= S_CHECK;
							end
						end
						OP_KILL: begin
							if (ent.id == tid_q) begin
								out_v <= 1'b1;
								sh_q <= idx_q;
								after_kill_q <= 1'b1;
								state_q <= S_SHRD;
							end else begin
								idx_q <= idx_q + CW'(1); state_q <= S_CHECK;
							end
						end
						OP_TICK: begin
							state_q <= S_CHECK;
							out_last <= 1'b0;
							if (ent.running) begin
								any_q <= 1'b1;
								out_v <= 1'b1;
								if (dec == 32'd0) begin
									out_term <= 1'b1;
									sh_q <= idx_q;
									after_kill_q <= 1'b0;
									state_q <= S_SHRD;
								end else
									idx_q <= idx_q + CW'(1);
							end else
								idx_q <= idx_q + CW'(1);
						end
						default: begin
							any_q <= 1'b1;
							out_v <= 1'b1;
							out_last <= (idx_q + CW'(1) >= used_q);
							idx_q <= idx_q + CW'(1);
							state_q <= (idx_q + CW'(1) >= used_q) ? S_DONE : S_CHECK;
						end
					endcase
				end
				S_SHRD: begin
					if (sh_q + CW'(1) >= used_q) begin
						used_q <= used_q - CW'(1);
						state_q <= after_kill_q ? S_DONE : S_CHECK;
					end else
						state_q <= S_SHWR;
				end
				S_SHWR: begin
					sh_q <= sh_q + CW'(1);
					state_q <= S_SHRD;
				end
				S_WRNEW: begin
					used_q <= used_q + CW'(1);
					next_id_q <= next_id_q + 16'd1;
					out_v <= 1'b1;
					out_st <= ST_OK;
					out_e.id <= next_id_q;
					out_e.name_low <= nlo_q;
					out_e.name_high <= nhi_q;
					out_e.count <= cnt_q;
					out_e.running <= 1'b0;
					out_last <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tick results are held one step so the final one can carry last
	logic hold_v_q;
	status_t hold_st_q;
	entry_t hold_e_q;
	logic hold_term_q;
	logic tick_emit;
	logic tick_end;
	assign tick_emit = out_v && (op_q == OP_TICK) && !out_last;
	assign tick_end = (op_q == OP_TICK) && (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (op_q == OP_TICK && out_v && out_st == ST_EMPTY) begin
				strobe <= 1'b1;
				status <= out_st; last <= 1'b1;
				proc_id <= '0; out_name_low <= '0; out_name_high <= '0;
				remaining <= '0; is_running <= 1'b0; terminated <= 1'b0;
			end else if (tick_emit) begin
				hold_v_q <= 1'b1;
				hold_st_q <= out_st;
				hold_e_q <= out_e;
				hold_term_q <= out_term;
				if (hold_v_q) begin
					strobe <= 1'b1; last <= 1'b0;
					status <= hold_st_q; proc_id <= hold_e_q.id;
					out_name_low <= hold_e_q.name_low;
					out_name_high <= hold_e_q.name_high;
					remaining <= hold_e_q.count;
					is_running <= hold_e_q.running;
					terminated <= hold_term_q;
				end
			end else if (tick_end && hold_v_q) begin
				hold_v_q <= 1'b0;
				strobe <= 1'b1; last <= 1'b1;
				status <= hold_st_q; proc_id <= hold_e_q.id;
				out_name_low <= hold_e_q.name_low;
				out_name_high <= hold_e_q.name_high;
				remaining <= hold_e_q.count;
				is_running <= hold_e_q.running;
				terminated <= hold_term_q;
			end else if (out_v && op_q != OP_TICK) begin
				strobe <= 1'b1; last <= out_last;
				status <= out_st; proc_id <= out_e.id;
				out_name_low <= out_e.name_low;
				out_name_high <= out_e.name_high;
				remaining <= out_e.count;
				is_running <= out_e.running;
				terminated <= out_term;
			end
		end
	end

	assign busy = (state_q != S_IDLE) || out_v || strobe || hold_v_q;

endmodule
